// File: hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VNA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vna assertion failed");

// next-cycle implication, disabled while in reset
`define VNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vna assertion failed");

`endif

// File: hdl/vna_pkg.sv
package vna_pkg;

    localparam int IDX_W        = 12;
    localparam int COORD_BITS   = 16;
    localparam int SUM_W        = 48;
    localparam int NORM_W       = 16;
    localparam int VERTEX_DEPTH = 4096;

    // opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic [IDX_W-1:0]              index_a;
        logic [IDX_W-1:0]              index_b;
        logic [IDX_W-1:0]              index_c;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic signed [COORD_BITS-1:0]  coord_z;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]          vertex_id;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic                      zero_length;
    } t_out_item;

    // index modulo depth by conditional subtraction of shifted depth
    function automatic logic [IDX_W-1:0] reduce_index(input logic [IDX_W-1:0] v,
                                                     input int depth);
        logic [31:0] r;
        logic [31:0] d;
        r = 32'(v);
        for (int k = IDX_W - 1; k >= 0; k--) begin
            d = 32'(depth) << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[IDX_W-1:0];
    endfunction

endpackage

// File: hdl/vna_in_if.sv
interface vna_in_if;
    logic                 valid;
    logic                 ready;
    vna_pkg::t_in_item    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/vna_out_if.sv
interface vna_out_if;
    logic                 valid;
    logic                 ready;
    vna_pkg::t_out_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/vertex_normal_accumulator_core.sv
// area-weighted vertex normal accumulator, fixed point
// input channel i_in (valid/ready) carries an opcode, three vertex indices and
// three Q2.14 coordinates; output channel o_out returns one normal per read
// load: stores the vertex and clears its normal sum, done in the accept cycle
// triangle: three vertex-memory reads, edges, cross product, then one
//   read-modify-write of the sum memory per corner
// read: sum read, magnitude, one right shift per cycle until below 2^30
//   (up to 18), nine multiply-accumulates for the squared length, a 32-step
//   square root and a 16-step divider per component, all skipped for a zero sum
// the sequencer takes one transaction at a time; i_in.ready is high when idle
// results sit in an output register, so the next transaction is taken while
// a result waits; a finished read holds in its last step until the register
// is free, so a stalled receiver stalls the block only then
// reset clears the sequencer and the output valid; the memories are not
// cleared, a vertex must be loaded before it is used
module vertex_normal_accumulator_core #(
    parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vna_in_if.sink           i_in,
    vna_out_if.source        o_out
);

`include "assert_macros.svh"

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int IW = vna_pkg::IDX_W;
    localparam int CW = vna_pkg::COORD_BITS;
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;
    localparam int SW = vna_pkg::SUM_W;
    localparam int QW = vna_pkg::NORM_W;
    localparam int VW = 3 * CW;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_VRD    = 15'b000000000000010,
        S_EDGE   = 15'b000000000000100,
        S_MUL    = 15'b000000000001000,
        S_CROSS  = 15'b000000000010000,
        S_ACC_RD = 15'b000000000100000,
        S_ACC_WR = 15'b000000001000000,
        S_NRD    = 15'b000000010000000,
        S_NMAG   = 15'b000000100000000,
        S_NSHIFT = 15'b000001000000000,
        S_SQ     = 15'b000010000000000,
        S_SQRT   = 15'b000100000000000,
        S_DSET   = 15'b001000000000000,
        S_DIV    = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } t_state;

    // memories
    logic [VW-1:0]   mem_v [VERTEX_DEPTH];
    logic [3*SW-1:0] mem_s [VERTEX_DEPTH];

    t_state                r_state;
    logic [AW-1:0]         r_ia, r_ib, r_ic;
    logic [1:0]            r_k;
    logic [VW-1:0]         r_vq;
    logic [3*SW-1:0]       r_sq;
    logic [VW-1:0]         r_ca, r_cb, r_cc;
    logic signed [EW-1:0]  r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [PW-1:0]  r_p [6];
    logic signed [NW-1:0]  r_nx, r_ny, r_nz;
    logic [SW-1:0]         r_m [3];
    logic                  r_neg [3];
    logic [1:0]            r_comp, r_part;
    logic [61:0]           r_acc;
    logic [63:0]           r_root, r_bit;
    logic [31:0]           r_len;
    logic [46:0]           r_drem, r_dvs;
    logic [QW-1:0]         r_q;
    logic [3:0]            r_dcnt;
    logic [QW-1:0]         r_nrm [3];
    logic                  r_zero;
    logic                  r_ovalid;
    vna_pkg::t_out_item    r_out;

    logic [AW-1:0]         n_ia, n_ib, n_ic, c_corner;
    logic                  vtx_we, sum_we;
    logic [AW-1:0]         vtx_ra, sum_ra, sum_wa;
    logic [3*SW-1:0]       sum_wd;
    logic [29:0]           sq_op;
    logic [29:0]           sq_prod;
    logic [61:0]           sq_add;
    logic [63:0]           rt_try, n_root;
    logic                  rt_ge;
    logic                  dv_ge;
    logic [QW-1:0]         dv_q;

    function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] v);
        logic [16:0] w;
        w = 17'(vna_pkg::reduce_index(v, VERTEX_DEPTH));
        return w[AW-1:0];
    endfunction

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                              input logic signed [NW-1:0] d);
        logic signed [SW:0] t;
        t = $signed({s[SW-1], s}) + (SW + 1)'(d);
        if (t[SW] != t[SW-1]) begin
            return t[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end
        return t[SW-1:0];
    endfunction

    // index reduction and corner select
    always_comb begin
        n_ia = to_addr(i_in.data.index_a);
        n_ib = to_addr(i_in.data.index_b);
        n_ic = to_addr(i_in.data.index_c);
        case (r_k)
            2'd0:    c_corner = r_ia;
            2'd1:    c_corner = r_ib;
            default: c_corner = r_ic;
        endcase
    end

    // memory port control
    always_comb begin
        vtx_we = 1'b0;
        sum_we = 1'b0;
        vtx_ra = c_corner;
        sum_ra = (r_state == S_NRD) ? r_ia : c_corner;
        sum_wa = c_corner;
        sum_wd = {sat_add(r_sq[3*SW-1:2*SW], r_nz),
                  sat_add(r_sq[2*SW-1:SW], r_ny),
                  sat_add(r_sq[SW-1:0], r_nx)};
        if (r_state == S_IDLE && i_in.valid && i_in.data.opcode == vna_pkg::OP_LOAD) begin
            vtx_we = 1'b1;
            sum_we = 1'b1;
            sum_wa = n_ia;
            sum_wd = '0;
        end else if (r_state == S_ACC_WR) begin
            sum_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vtx_we) begin
            mem_v[n_ia] <= {i_in.data.coord_z, i_in.data.coord_y, i_in.data.coord_x};
        end
        r_vq <= mem_v[vtx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            mem_s[sum_wa] <= sum_wd;
        end
        r_sq <= mem_s[sum_ra];
    end

    // squared length: one 15x15 partial product per cycle
    always_comb begin
        sq_op = r_m[r_comp][29:0];
        case (r_part)
            2'd0: begin
                sq_prod = 30'(sq_op[29:15] * sq_op[29:15]);
                sq_add  = 62'(sq_prod) << 30;
            end
            2'd1: begin
                sq_prod = 30'(sq_op[29:15] * sq_op[14:0]);
                sq_add  = 62'(sq_prod) << 16;
            end
            default: begin
                sq_prod = 30'(sq_op[14:0] * sq_op[14:0]);
                sq_add  = 62'(sq_prod);
            end
        endcase
    end

    // square root step and divider step
    always_comb begin
        rt_try = r_root + r_bit;
        rt_ge  = 64'(r_acc) >= rt_try;
        n_root = rt_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
        dv_ge  = r_drem >= r_dvs;
        dv_q   = {r_q[QW-2:0], dv_ge};
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ia <= n_ia;
                        r_ib <= n_ib;
                        r_ic <= n_ic;
                        r_k  <= 2'd0;
                        case (i_in.data.opcode)
                            vna_pkg::OP_TRI:  r_state <= S_VRD;
                            vna_pkg::OP_READ: r_state <= S_NRD;
                            default:          r_state <= S_IDLE;
                        endcase
                    end
                end
                S_VRD: begin
                    r_k <= r_k + 2'd1;
                    case (r_k)
                        2'd1:    r_ca <= r_vq;
                        2'd2:    r_cb <= r_vq;
                        2'd3: begin
                            r_cc    <= r_vq;
                            r_state <= S_EDGE;
                        end
                        default: r_ca <= r_ca;
                    endcase
                end
                S_EDGE: begin
                    r_e1x <= EW'($signed(r_cb[CW-1:0]))      - EW'($signed(r_ca[CW-1:0]));
                    r_e1y <= EW'($signed(r_cb[2*CW-1:CW]))   - EW'($signed(r_ca[2*CW-1:CW]));
                    r_e1z <= EW'($signed(r_cb[3*CW-1:2*CW])) - EW'($signed(r_ca[3*CW-1:2*CW]));
                    r_e2x <= EW'($signed(r_cc[CW-1:0]))      - EW'($signed(r_ca[CW-1:0]));
                    r_e2y <= EW'($signed(r_cc[2*CW-1:CW]))   - EW'($signed(r_ca[2*CW-1:CW]));
                    r_e2z <= EW'($signed(r_cc[3*CW-1:2*CW])) - EW'($signed(r_ca[3*CW-1:2*CW]));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p[0]  <= r_e1y * r_e2z;
                    r_p[1]  <= r_e1z * r_e2y;
                    r_p[2]  <= r_e1z * r_e2x;
                    r_p[3]  <= r_e1x * r_e2z;
                    r_p[4]  <= r_e1x * r_e2y;
                    r_p[5]  <= r_e1y * r_e2x;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_nx    <= NW'(r_p[0]) - NW'(r_p[1]);
                    r_ny    <= NW'(r_p[2]) - NW'(r_p[3]);
                    r_nz    <= NW'(r_p[4]) - NW'(r_p[5]);
                    r_k     <= 2'd0;
                    r_state <= S_ACC_RD;
                end
                S_ACC_RD: begin
                    r_state <= S_ACC_WR;
                end
                S_ACC_WR: begin
                    r_k     <= r_k + 2'd1;
                    r_state <= (r_k == 2'd2) ? S_IDLE : S_ACC_RD;
                end
                S_NRD: begin
                    r_state <= S_NMAG;
                end
                S_NMAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= r_sq[SW*i+SW-1];
                        r_m[i]   <= r_sq[SW*i+SW-1] ? (SW'(0) - r_sq[SW*i +: SW])
                                                    : r_sq[SW*i +: SW];
                    end
                    if (r_sq == '0) begin
                        r_zero  <= 1'b1;
                        r_nrm   <= '{default: '0};
                        r_state <= S_OUT;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= S_NSHIFT;
                    end
                end
                S_NSHIFT: begin
                    if ((|r_m[0][SW-1:30]) || (|r_m[1][SW-1:30]) || (|r_m[2][SW-1:30])) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else begin
                        r_acc   <= '0;
                        r_comp  <= 2'd0;
                        r_part  <= 2'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_acc <= r_acc + sq_add;
                    if (r_part == 2'd2) begin
                        r_part <= 2'd0;
                        r_comp <= r_comp + 2'd1;
                        if (r_comp == 2'd2) begin
                            r_root  <= '0;
                            r_bit   <= 64'd1 << 62;
                            r_state <= S_SQRT;
                        end
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
                S_SQRT: begin
                    if (rt_ge) begin
                        r_acc <= 62'(64'(r_acc) - rt_try);
                    end
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_len   <= n_root[31:0];
                        r_comp  <= 2'd0;
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    r_drem  <= (47'(r_m[r_comp][29:0]) << 14) + 47'(r_len >> 1);
                    r_dvs   <= 47'(r_len) << 15;
                    r_q     <= '0;
                    r_dcnt  <= 4'd15;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (dv_ge) begin
                        r_drem <= r_drem - r_dvs;
                    end
                    r_dvs  <= r_dvs >> 1;
                    r_q    <= dv_q;
                    r_dcnt <= r_dcnt - 4'd1;
                    if (r_dcnt == 4'd0) begin
                        r_nrm[r_comp] <= r_neg[r_comp] ? (QW'(0) - dv_q) : dv_q;
                        r_comp        <= r_comp + 2'd1;
                        r_state       <= (r_comp == 2'd2) ? S_OUT : S_DSET;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_out.vertex_id   <= IW'(r_ia);
                        r_out.normal_x    <= r_nrm[0];
                        r_out.normal_y    <= r_nrm[1];
                        r_out.normal_z    <= r_nrm[2];
                        r_out.zero_length <= r_zero;
                        r_ovalid          <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `VNA_ASSERT_IMPL(a_zero_normal, i_clk, i_rst_n, o_out.valid && o_out.data.zero_length, o_out.data.normal_x == 0 && o_out.data.normal_y == 0 && o_out.data.normal_z == 0)
    `VNA_ASSERT_NEXT(a_tri_start, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.data.opcode == vna_pkg::OP_TRI, r_state == S_VRD)
    `VNA_ASSERT_IMPL(a_norm_range, i_clk, i_rst_n, o_out.valid, o_out.data.normal_x >= -16'sd16384 && o_out.data.normal_x <= 16'sd16384 && o_out.data.normal_y >= -16'sd16384 && o_out.data.normal_y <= 16'sd16384 && o_out.data.normal_z >= -16'sd16384 && o_out.data.normal_z <= 16'sd16384)

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int IW = vna_pkg::IDX_W;
    localparam int CB = vna_pkg::COORD_BITS;
    localparam int DEPTH = vna_pkg::VERTEX_DEPTH;
    localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_8000_0000_0000;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vna_in_if  in_ch ();
    vna_out_if out_ch ();

    vertex_normal_accumulator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [CB-1:0] pos_x [DEPTH];
    logic signed [CB-1:0] pos_y [DEPTH];
    logic signed [CB-1:0] pos_z [DEPTH];
    longint acc_x [DEPTH];
    longint acc_y [DEPTH];
    longint acc_z [DEPTH];
    bit     loaded [DEPTH];
    int     loaded_list [$];

    vna_pkg::t_out_item pending_normals [$];
    int  mismatch_count = 0;
    longint cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint sat_add(longint s, longint d);
        longint r;
        r = s + d;
        if (r > SAT_HI) return SAT_HI;
        if (r < SAT_LO) return SAT_LO;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] unit_component(longint v, int sh, longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = ((v < 0) ? -v : v) >> sh;
        q = ((m << 14) + (len >> 1)) / len;
        if (v < 0) q = -q;
        return q[15:0];
    endfunction

    // apply one transaction to the predictor
    task automatic predict_normals(input vna_pkg::t_in_item it);
        int a, b, c, sh, k;
        int corner [3];
        longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        longint unsigned mx, my, mz, big, len;
        vna_pkg::t_out_item r;
        a = int'(it.index_a) % DEPTH;
        case (it.opcode)
            vna_pkg::OP_LOAD: begin
                pos_x[a] = it.coord_x;
                pos_y[a] = it.coord_y;
                pos_z[a] = it.coord_z;
                acc_x[a] = 0;
                acc_y[a] = 0;
                acc_z[a] = 0;
                if (!loaded[a]) loaded_list.insert(loaded_list.size(), a);
                loaded[a] = 1'b1;
            end
            vna_pkg::OP_TRI: begin
                b = int'(it.index_b) % DEPTH;
                c = int'(it.index_c) % DEPTH;
                e1x = longint'(pos_x[b]) - pos_x[a];
                e1y = longint'(pos_y[b]) - pos_y[a];
                e1z = longint'(pos_z[b]) - pos_z[a];
                e2x = longint'(pos_x[c]) - pos_x[a];
                e2y = longint'(pos_y[c]) - pos_y[a];
                e2z = longint'(pos_z[c]) - pos_z[a];
                nx = e1y * e2z - e1z * e2y;
                ny = e1z * e2x - e1x * e2z;
                nz = e1x * e2y - e1y * e2x;
                corner[0] = a;
                corner[1] = b;
                corner[2] = c;
                for (k = 0; k < 3; k++) begin
                    acc_x[corner[k]] = sat_add(acc_x[corner[k]], nx);
                    acc_y[corner[k]] = sat_add(acc_y[corner[k]], ny);
                    acc_z[corner[k]] = sat_add(acc_z[corner[k]], nz);
                end
            end
            vna_pkg::OP_READ: begin
                mx = (acc_x[a] < 0) ? -acc_x[a] : acc_x[a];
                my = (acc_y[a] < 0) ? -acc_y[a] : acc_y[a];
                mz = (acc_z[a] < 0) ? -acc_z[a] : acc_z[a];
                big = mx;
                if (my > big) big = my;
                if (mz > big) big = mz;
                r = '0;
                r.vertex_id = IW'(a);
                if (big == 0) begin
                    r.zero_length = 1'b1;
                end else begin
                    sh = 0;
                    while ((big >> sh) >= (64'd1 << 30)) sh++;
                    len = int_sqrt((mx >> sh) * (mx >> sh) + (my >> sh) * (my >> sh)
                                   + (mz >> sh) * (mz >> sh));
                    r.normal_x = unit_component(acc_x[a], sh, len);
                    r.normal_y = unit_component(acc_y[a], sh, len);
                    r.normal_z = unit_component(acc_z[a], sh, len);
                end
                pending_normals.insert(pending_normals.size(), r);
            end
            default: ;
        endcase
    endtask

    // send one transaction, idling before it at random
    task automatic send_item(input vna_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        predict_normals(it);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver stall
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // check each result
    always @(posedge i_clk) begin
        vna_pkg::t_out_item exp_n;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_normals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", out_ch.data);
            end else begin
                exp_n = pending_normals.pop_front();
                if (out_ch.data.vertex_id !== exp_n.vertex_id ||
                    out_ch.data.normal_x !== exp_n.normal_x ||
                    out_ch.data.normal_y !== exp_n.normal_y ||
                    out_ch.data.normal_z !== exp_n.normal_z ||
                    out_ch.data.zero_length !== exp_n.zero_length) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_n, out_ch.data);
                end
            end
        end
    end

    function automatic vna_pkg::t_in_item make_item(logic [1:0] op, int a, int b, int c,
                                                    int x, int y, int z);
        vna_pkg::t_in_item it;
        it.opcode  = op;
        it.index_a = IW'(a);
        it.index_b = IW'(b);
        it.index_c = IW'(c);
        it.coord_x = CB'(x);
        it.coord_y = CB'(y);
        it.coord_z = CB'(z);
        return it;
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    // stop sending and wait until every expected result has come
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_normals.size() != 0) @(negedge i_clk);
    endtask

    // extremes, zero sum, large sums, repeated corners, ignored opcode
    task automatic test_directed();
        int k;
        send_item(make_item(vna_pkg::OP_LOAD, 0, 0, 0, -32768, -32768, -32768));
        send_item(make_item(vna_pkg::OP_LOAD, 4095, 0, 0, 32767, 32767, 32767));
        send_item(make_item(vna_pkg::OP_LOAD, 1, 0, 0, 32767, -32768, 0));
        send_item(make_item(vna_pkg::OP_LOAD, 2, 0, 0, -32768, 32767, 32767));
        send_item(make_item(vna_pkg::OP_READ, 0, 4095, 4095, 0, 0, 0));
        send_item(make_item(vna_pkg::OP_TRI, 0, 0, 0, 0, 0, 0));
        send_item(make_item(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
        send_item(make_item(vna_pkg::OP_TRI, 4095, 4095, 1, 0, 0, 0));
        send_item(make_item(vna_pkg::OP_TRI, 0, 1, 2, -1, -1, -1));
        send_item(make_item(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
        send_item(make_item(vna_pkg::OP_READ, 1, 0, 0, 0, 0, 0));
        send_item(make_item(vna_pkg::OP_READ, 2, 0, 0, 0, 0, 0));
        send_item(make_item(OP_NONE, 4095, 4095, 4095, -1, -1, -1));
        // grow the sums with a large face repeated
        for (k = 0; k < 8; k++) send_item(make_item(vna_pkg::OP_TRI, 0, 1, 2, 0, 0, 0));
        send_item(make_item(vna_pkg::OP_READ, 1, 0, 0, 0, 0, 0));
        send_item(make_item(vna_pkg::OP_READ, 4095, 0, 0, 0, 0, 0));
        // pause until all results are out
        drain_results();
    endtask

    // mostly triangles and reads over a small loaded set
    task automatic test_random(input int count);
        int k, sel, a;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 15 || loaded_list.size() < 3) begin
                a = (loaded_list.size() > 40 && sel < 10) ? pick_loaded()
                                                          : $urandom_range(4095);
                send_item(make_item(vna_pkg::OP_LOAD, a, $urandom_range(4095),
                    $urandom_range(4095), $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(65535)));
            end else if (sel < 60) begin
                send_item(make_item(vna_pkg::OP_TRI, pick_loaded(), pick_loaded(),
                    pick_loaded(), $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(65535)));
            end else if (sel < 96) begin
                send_item(make_item(vna_pkg::OP_READ, pick_loaded(), $urandom_range(4095),
                    $urandom_range(4095), $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(65535)));
            end else begin
                send_item(make_item(OP_NONE, $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(4095), $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(65535)));
            end
        end
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 14;
        recv_stall_pct = 63;
        test_directed();
        test_random(260);
        send_idle_pct  = 63;
        recv_stall_pct = 14;
        test_random(260);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(260);

        drain_results();
        repeat (200) @(negedge i_clk);
        if (mismatch_count == 0 && pending_normals.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
